// ----- rtl/mbe_pkg.sv -----
// Package for the Mandelbrot escape-time test block.
// Holds field widths, reset values and the structs passed between the front queue,
// the iteration core and the top level. No dependencies.
package mbe_pkg;

  // Field widths of the request and result channels
  localparam int C_W    = 32;
  localparam int ITER_W = 16;
  localparam int CNT_W  = 32;

  // Default fraction bits of the fixed-point format (Q4.28)
  localparam int FRAC_BITS_DEF = 28;

  // Iteration limit after reset
  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(1000);

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;

  // One queued request
  typedef struct packed {
    logic [C_W-1:0] c_re;
    logic [C_W-1:0] c_im;
    logic           restart;
  } mbe_item_t;

  // Result status from the core to the top level
  typedef struct packed {
    logic              escaped;
    logic [ITER_W-1:0] iters;
    logic              restart;
  } mbe_res_t;

endpackage

// ----- rtl/mbe_front.sv -----
// Front end of the escape-time block: accepts requests into a short queue.
// Depends on mbe_pkg for the request struct and the queue depth.
module mbe_front (
  input  logic              clk,
  input  logic              rst_n,
  // request side
  input  logic              in_valid,
  output logic              in_stall,
  input  mbe_pkg::mbe_item_t push_item,
  // core side
  output logic              q_valid,
  input  logic              q_pop,
  output mbe_pkg::mbe_item_t q_item
);

  localparam int DEPTH = mbe_pkg::QDEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mbe_pkg::mbe_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  // Stall the sender while the queue is full
  assign in_stall = (cnt_r == CNT_W'(DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the accepted request
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) && !push |=> (cnt_r == '0))
    else $error("queue count rose without a push");

endmodule

// ----- rtl/mbe_core.sv -----
// Back end of the escape-time block: iterates z = z*z + c on one point at a time.
// Depends on mbe_pkg for the request and result structs and the field widths.
module mbe_core #(
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [mbe_pkg::ITER_W-1:0] max_iter,
  // queue side
  input  logic                      q_valid,
  output logic                      q_pop,
  input  mbe_pkg::mbe_item_t         q_item,
  // result side
  output logic                      res_valid,
  input  logic                      res_take,
  output mbe_pkg::mbe_res_t          res
);

  localparam int C_W    = mbe_pkg::C_W;
  localparam int ITER_W = mbe_pkg::ITER_W;
  // z holds c itself or any value inside [-2.0, 2.0]
  localparam int ZW = (FRAC_BITS + 3 > C_W) ? FRAC_BITS + 3 : C_W;
  localparam int PW = 2 * ZW;
  localparam int WW = PW + 2;

  localparam logic signed [WW-1:0] TWO     = {{(WW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
  localparam logic signed [WW-1:0] NEG_TWO = -TWO;
  localparam logic [PW:0]          FOUR_SQ = {{PW{1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ADD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic signed [ZW-1:0]     zr_r, zi_r;
  logic signed [C_W-1:0]    cre_r, cim_r;
  logic                     restart_r;
  logic                     big_r;
  logic [ITER_W-1:0]        n_r;
  logic                     esc_r;
  logic signed [PW-1:0]     prr_r, pii_r, pri_r;

  logic signed [WW-1:0]     diff, nr_full, ni_full;
  logic [PW:0]              sq_sum;
  logic                     big_nxt, esc_now, at_limit;

  // Form the next z and the escape test of the current z from registered products
  always_comb begin
    diff    = WW'(prr_r) - WW'(pii_r);
    nr_full = (diff >>> FRAC_BITS) + WW'(cre_r);
    ni_full = (WW'(pri_r) >>> (FRAC_BITS - 1)) + WW'(cim_r);
    big_nxt = (nr_full > TWO) || (nr_full < NEG_TWO) ||
              (ni_full > TWO) || (ni_full < NEG_TWO);
    sq_sum  = {1'b0, prr_r} + {1'b0, pii_r};
    esc_now = (n_r != '0) && (big_r || (sq_sum > FOUR_SQ));
    at_limit = (n_r == max_iter);
  end

  // Sequence: load point, multiply, update or finish, hand off result
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: begin
        if (esc_now || at_limit) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          cre_r     <= $signed(q_item.c_re);
          cim_r     <= $signed(q_item.c_im);
          zr_r      <= ZW'($signed(q_item.c_re));
          zi_r      <= ZW'($signed(q_item.c_im));
          restart_r <= q_item.restart;
          big_r     <= 1'b0;
          n_r       <= '0;
        end
      end
      S_MUL: begin
        prr_r <= PW'(zr_r * zr_r);
        pii_r <= PW'(zi_r * zi_r);
        pri_r <= PW'(zr_r * zi_r);
      end
      S_ADD: begin
        esc_r <= esc_now;
        if (!esc_now && !at_limit) begin
          zr_r  <= nr_full[ZW-1:0];
          zi_r  <= ni_full[ZW-1:0];
          big_r <= big_nxt;
          n_r   <= n_r + 1'b1;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assign res_valid   = (state_r == S_DONE);
  assign res.escaped = esc_r;
  assign res.iters   = n_r;
  assign res.restart = restart_r;

  a_esc_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.escaped |-> (res.iters != '0))
    else $error("escape reported with zero iterations");

  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.escaped |-> (res.iters == max_iter))
    else $error("non-escaped point did not run to the limit");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (n_r <= max_iter))
    else $error("iteration count passed the limit");

endmodule

// ----- rtl/mandelbrot_escape_test.sv -----
// Top level of the Mandelbrot escape-time test: limit register, escaped-point
// count and output register. Depends on mbe_pkg, mbe_front and mbe_core.
//
// Usage:
//   Requests (in_c_re, in_c_im, in_restart) enter on in_valid when in_stall is low.
//   c is signed fixed point with FRAC_BITS fraction bits (Q4.28 by default).
//   Each point gives one result (out_escaped, out_iterations_used,
//   out_outside_count), taken on out_valid when out_stall is low.
//   A two-entry queue sits in front of the iteration core, so new points are taken
//   while the core works and while a result waits in the output register.
//   A point passes the queue, the core loop and the output register before out_valid
//   rises. Each iteration of the core loop runs S_MUL for the three z products, then
//   S_ADD for the update and the escape compare. Points run through the core one at
//   a time: the core takes the next point only after its last result is handed off.
//   The limit (cfg_wr_data) is written on cfg_wr_en while the block is idle;
//   a limit of zero gives escaped 0 and zero iterations.
//   Reset sets the limit to 1000, clears the count and empties the queue.
//   When the receiver stalls, the result holds; the core finishes the next point and
//   waits, then the queue fills and in_stall rises.
module mandelbrot_escape_test #(
  parameter int FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [mbe_pkg::ITER_W-1:0] cfg_wr_data,
  // requests
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [mbe_pkg::C_W-1:0] in_c_re,
  input  logic signed [mbe_pkg::C_W-1:0] in_c_im,
  input  logic                       in_restart,
  // results
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_escaped,
  output logic [mbe_pkg::ITER_W-1:0] out_iterations_used,
  output logic [mbe_pkg::CNT_W-1:0]  out_outside_count
);

  localparam int CNT_W  = mbe_pkg::CNT_W;
  localparam int ITER_W = mbe_pkg::ITER_W;

  logic [ITER_W-1:0]  max_iter_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_base;
  logic               out_valid_r;
  logic               out_escaped_r;
  logic [ITER_W-1:0]  out_iters_r;

  mbe_pkg::mbe_item_t push_item, q_item;
  mbe_pkg::mbe_res_t  res;
  logic               q_valid, q_pop;
  logic               res_valid, res_take, res_fire;

  assign push_item.c_re    = in_c_re;
  assign push_item.c_im    = in_c_im;
  assign push_item.restart = in_restart;

  mbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .push_item (push_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  mbe_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_iter  (max_iter_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Hold the iteration limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= mbe_pkg::MAX_ITER_RST;
    end else if (cfg_wr_en) begin
      max_iter_r <= cfg_wr_data;
    end
  end

  // Take a finished result when the output register is empty or draining
  assign res_take = !out_valid_r || !out_stall;
  assign res_fire = res_valid && res_take;

  // Drop the count on restart, then add an escaped point, saturating
  always_comb begin
    cnt_base = res.restart ? '0 : cnt_r;
    cnt_nxt  = cnt_base;
    if (res.escaped && (cnt_base != '1)) begin
      cnt_nxt = cnt_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (res_fire) begin
        cnt_r <= cnt_nxt;
      end
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_escaped_r <= res.escaped;
      out_iters_r   <= res.iters;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_escaped         = out_escaped_r;
  assign out_iterations_used = out_iters_r;
  assign out_outside_count   = cnt_r;

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire && !res.restart && (cnt_r == '1) |=> (cnt_r == '1))
    else $error("escaped-point count wrapped");

endmodule

// ----- bench/tb_mandelbrot_escape_test.sv -----
`timescale 1ns / 100ps
// Testbench for mandelbrot_escape_test: drives points through the request channel,
// predicts escape flag, iteration count and escaped-point count in fixed point and
// checks every result in order. Depends on mbe_pkg and the RTL top level only.
module tb_mandelbrot_escape_test;

  localparam int C_W    = mbe_pkg::C_W;
  localparam int ITER_W = mbe_pkg::ITER_W;
  localparam int CNT_W  = mbe_pkg::CNT_W;
  localparam int FRAC = mbe_pkg::FRAC_BITS_DEF;
  localparam int Q_ONE = 1 << FRAC;
  localparam logic signed [C_W-1:0] C_MAX = 32'sh7fff_ffff;
  localparam logic signed [C_W-1:0] C_MIN = 32'sh8000_0000;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int MAX_REPORTS = 10;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  typedef struct {
    logic              escaped;
    logic [ITER_W-1:0] iters;
    logic [CNT_W-1:0]  count;
  } escape_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [ITER_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [C_W-1:0] in_c_re = '0;
  logic signed [C_W-1:0] in_c_im = '0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_escaped;
  logic [ITER_W-1:0] out_iterations_used;
  logic [CNT_W-1:0] out_outside_count;

  // Predictor state
  logic [ITER_W-1:0] iter_limit = mbe_pkg::MAX_ITER_RST;
  logic [CNT_W-1:0] escaped_total = '0;
  escape_res_t expected_points[$];

  // Traffic shaping
  stall_mode_t stall_mode = STALL_NONE;
  int gap_max = 0;
  int burst_left = 0;
  int hold_len_req = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  int cycle_count = 0;
  int fail_count = 0;
  int mismatch_count = 0;

  mandelbrot_escape_test i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_c_re             (in_c_re),
    .in_c_im             (in_c_im),
    .in_restart          (in_restart),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_escaped         (out_escaped),
    .out_iterations_used (out_iterations_used),
    .out_outside_count   (out_outside_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // True once z lies outside the radius-2 circle, tested exactly
  function automatic bit beyond_radius(longint zr, longint zi);
    longint two_q;
    longint mag_sq;
    two_q = longint'(2) <<< FRAC;
    if (zr > two_q || -zr > two_q || zi > two_q || -zi > two_q) return 1'b1;
    mag_sq = zr * zr + zi * zi;
    return mag_sq > (longint'(4) <<< (2 * FRAC));
  endfunction

  // Iterate z = z*z + c from z = c and advance the escaped-point count
  function automatic escape_res_t escape_time_of(logic signed [C_W-1:0] re,
                                                 logic signed [C_W-1:0] im,
                                                 logic clear);
    longint cr, ci, zr, zi, nr, ni;
    int unsigned n;
    escape_res_t res;
    cr = re;
    ci = im;
    zr = cr;
    zi = ci;
    n = 0;
    res.escaped = 1'b0;
    res.iters = iter_limit;
    if (clear) escaped_total = '0;
    while (n < iter_limit && !res.escaped) begin
      // floor division by arithmetic shift; 2*zr*zi uses one bit less of shift
      nr = ((zr * zr - zi * zi) >>> FRAC) + cr;
      ni = ((zr * zi) >>> (FRAC - 1)) + ci;
      zr = nr;
      zi = ni;
      if (beyond_radius(zr, zi)) begin
        res.escaped = 1'b1;
        res.iters = ITER_W'(n + 1);
      end
      n++;
    end
    if (res.escaped && escaped_total != '1) escaped_total++;
    res.count = escaped_total;
    return res;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result stall: long hold-off on request, else the current pattern
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = hold_len_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: out_stall <= ((cycle_count % 7) < 3);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    escape_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result esc=%0b iters=%0d count=%0d", $realtime,
                   out_escaped, out_iterations_used, out_outside_count);
      end else begin
        want = expected_points.pop_front();
        if (out_escaped !== want.escaped || out_iterations_used !== want.iters ||
            out_outside_count !== want.count) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch (exp/got) esc %0b/%0b iters %0d/%0d count %0d/%0d",
                     $realtime, want.escaped, out_escaped, want.iters, out_iterations_used,
                     want.count, out_outside_count);
        end
      end
    end
  end

  // Offer one request in bursts with random gaps and record its prediction on accept
  task automatic send_point(input logic signed [C_W-1:0] re, input logic signed [C_W-1:0] im,
                            input logic clear);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gap_max > 0) gap = $urandom_range(1, gap_max);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_c_re <= re;
    in_c_im <= im;
    in_restart <= clear;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_points.push_back(escape_time_of(re, im, clear));
  endtask

  // Drop valid and hold until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the iteration limit while idle
  task automatic set_limit(input logic [ITER_W-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    iter_limit = value;
  endtask

  // Reset limit of 1000: points inside the set run to the limit
  task automatic test_default_limit();
    send_point(0, 0, 1'b1);
    send_point(-2 * Q_ONE, 0, 1'b0);
    send_point(Q_ONE / 4, 0, 1'b0);
    send_point(Q_ONE, 0, 1'b0);
    wait_idle();
  endtask

  // Field extremes, boundary points and the restart flag
  task automatic test_directed_points();
    set_limit(16);
    send_point(C_MAX, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, 1'b0);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(2 * Q_ONE, 0, 1'b0);
    send_point(0, Q_ONE, 1'b0);
    send_point(0, -Q_ONE, 1'b0);
    send_point(-Q_ONE, 0, 1'b0);
    send_point(-3 * Q_ONE / 4, Q_ONE / 10, 1'b0);
    send_point(1, -1, 1'b0);
    send_point(-1, 0, 1'b0);
    send_point(Q_ONE / 2, Q_ONE / 2, 1'b0);
    send_point(C_MAX, 0, 1'b1);
    send_point(0, 0, 1'b1);
    wait_idle();
  endtask

  // Zero, one and full-range iteration limits
  task automatic test_limit_extremes();
    set_limit(0);
    send_point(0, 0, 1'b0);
    send_point(C_MAX, C_MIN, 1'b0);
    set_limit(1);
    send_point(0, 0, 1'b0);
    send_point(Q_ONE, Q_ONE, 1'b0);
    send_point(2 * Q_ONE, 0, 1'b0);
    set_limit('1);
    send_point(0, 0, 1'b0);
    send_point(Q_ONE / 2, Q_ONE, 1'b0);
    wait_idle();
  endtask

  // Hold the result side long enough to fill the queue, then drain fully
  task automatic test_backpressure();
    set_limit(8);
    stall_mode = STALL_NONE;
    gap_max = 0;
    hold_len_req = 1500;
    hold_toggle = ~hold_toggle;
    repeat (12) send_point(0, 0, 1'b0);
    send_point(Q_ONE, 0, 1'b0);
    wait_idle();
  endtask

  // Random points, mostly near the set, under varied limits and traffic
  task automatic test_random_points();
    int unsigned num_points;
    logic signed [C_W-1:0] re, im;
    for (int p = 0; p < 8; p++) begin
      if (p == 0) set_limit(1);
      else if (p == 7) set_limit(1000);
      else set_limit(ITER_W'($urandom_range(2, 64)));
      num_points = (p == 7) ? 40 : 70;
      stall_mode = stall_mode_t'(p % 3);
      gap_max = (p % 2) ? 0 : 6;
      repeat (num_points) begin
        if ($urandom_range(0, 6) == 0) begin
          re = $urandom;
          im = $urandom;
        end else begin
          // window of [-2.5, 1.0] x [-1.5, 1.5]
          re = -5 * Q_ONE / 2 + int'($urandom_range(0, 7 * Q_ONE / 2));
          im = -3 * Q_ONE / 2 + int'($urandom_range(0, 3 * Q_ONE));
        end
        send_point(re, im, $urandom_range(0, 15) == 0);
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_limit();
    test_directed_points();
    test_limit_extremes();
    test_backpressure();
    test_random_points();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mbe_pkg.sv
rtl/mbe_front.sv
rtl/mbe_core.sv
rtl/mandelbrot_escape_test.sv
bench/tb_mandelbrot_escape_test.sv
